// File: hdl/sliding_window_airtime_tracker_unit_assert.svh
// Assertion macros shared by the airtime tracker modules
`ifndef SLIDING_WINDOW_AIRTIME_TRACKER_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_AIRTIME_TRACKER_UNIT_ASSERT_SVH

// checked only while out of reset
`define SWATU_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// checked on every edge, reset included
`define SWATU_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

// File: hdl/swatu_pkg.sv
// Constants, widths and controller/datapath interface types of the airtime tracker
package swatu_pkg;

    localparam int NUM_BUCKETS    = 60;
    localparam int BUCKET_MS      = 1000;
    localparam int WINDOW_MS      = 60000;
    localparam int PERMILLE_SCALE = 1000;

    localparam int REQ_W   = 2;
    localparam int TIME_W  = 32;
    localparam int AIR_W   = 16;
    localparam int LIMIT_W = 16;
    localparam int BKT_W   = 32;
    localparam int USED_W  = 38;
    localparam int PM_W    = 16;

    localparam int IDX_W  = $clog2(NUM_BUCKETS);
    localparam int CNT_W  = $clog2(NUM_BUCKETS + 1);
    localparam int DIST_W = $clog2(2 * NUM_BUCKETS);

    localparam longint TIME_MAX = (64'd1 << TIME_W) - 64'd1;
    localparam int SEC_W = $clog2(TIME_MAX / BUCKET_MS + 1);

    localparam int SUM_W = BKT_W + $clog2(NUM_BUCKETS);
    localparam int ACC_W = (SUM_W > USED_W) ? SUM_W : USED_W;

    // second = (now * SEC_RECIP) >> SEC_SHIFT, exact for every timestamp
    localparam int     SEC_SHIFT   = TIME_W + $clog2(BUCKET_MS);
    localparam longint SEC_RECIP   = ((64'd1 << SEC_SHIFT) + BUCKET_MS - 1) / BUCKET_MS;
    localparam int     SEC_RECIP_W = $clog2(SEC_RECIP + 1);

    // per mille saturates from PM_LIMIT on; below it a reciprocal product is exact
    localparam longint PM_LIMIT   =
        ((64'd1 << PM_W) * WINDOW_MS + PERMILLE_SCALE - 1) / PERMILLE_SCALE;
    localparam int     PM_X_W     = $clog2(PM_LIMIT);
    localparam int     PM_SHIFT   = PM_X_W + $clog2(WINDOW_MS);
    localparam longint PM_RECIP   =
        (PERMILLE_SCALE * (64'd1 << PM_SHIFT) + WINDOW_MS - 1) / WINDOW_MS;
    localparam int     PM_RECIP_W = $clog2(PM_RECIP + 1);

    localparam int MUL_A_W = (TIME_W > PM_X_W) ? TIME_W : PM_X_W;
    localparam int MUL_B_W = (SEC_RECIP_W > PM_RECIP_W) ? SEC_RECIP_W : PM_RECIP_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(6000);
    localparam logic [USED_W-1:0]  USED_MAX    = '1;

    // request codes; the unused code behaves as a query
    localparam logic [REQ_W-1:0] REQ_RECORD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    typedef struct packed {
        logic load_in;
        logic div_start_now;
        logic div_start_pm;
        logic clear_all;
        logic age;
        logic rec_rd;
        logic rec_wr;
        logic sum_clr;
        logic sum_step;
        logic used_latch;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             div_done;
        logic             sum_last;
    } dp_sta_t;

endpackage

// File: hdl/sliding_window_airtime_tracker_unit.sv
// Top level of the sliding-window airtime tracker
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------------
//  input    | s_valid / s_ready          | s_req_type, s_now_ms, s_airtime_ms
//  result   | m_valid / m_ready          | m_used_ms, m_allowed, m_used_per_mille
//  config   | cfg_valid / cfg_ready      | cfg_airtime_limit_ms
//
// One item at a time: s_ready falls once an item is taken and comes back together with m_valid.
// Most of the work per item is the sweep over the bucket RAM that forms the total; both
// divisions by constants are registered reciprocal products.
// After reset the block is ready at once; reset clears the bucket valid bits.
// While m_ready holds off a result, the next item waits finished in its final state.
// Configuration writes are taken on every cycle (cfg_ready is always high).
module sliding_window_airtime_tracker_unit import swatu_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [LIMIT_W-1:0]  cfg_airtime_limit_ms,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [REQ_W-1:0]    s_req_type,
    input  logic [TIME_W-1:0]   s_now_ms,
    input  logic [AIR_W-1:0]    s_airtime_ms,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [USED_W-1:0]   m_used_ms,
    output logic                m_allowed,
    output logic [PM_W-1:0]     m_used_per_mille
);

    dp_cmd_t cmd;
    dp_sta_t sta;

    assign cfg_ready = 1'b1;

    swatu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sta     (sta),
        .cmd     (cmd)
    );

    swatu_dp u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .sta                  (sta),
        .cfg_valid            (cfg_valid),
        .cfg_airtime_limit_ms (cfg_airtime_limit_ms),
        .s_req_type           (s_req_type),
        .s_now_ms             (s_now_ms),
        .s_airtime_ms         (s_airtime_ms),
        .m_used_ms            (m_used_ms),
        .m_allowed            (m_allowed),
        .m_used_per_mille     (m_used_per_mille)
    );

endmodule

// File: hdl/swatu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data
module swatu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/swatu_div.sv
// Divisions by the bucket length and by the window, as registered reciprocal products
module swatu_div import swatu_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start_sec,
    input  logic              start_pm,
    input  logic [TIME_W-1:0] now_ms,
    input  logic [USED_W-1:0] used_ms,
    output logic              done,
    output logic [SEC_W-1:0]  second,
    output logic [PM_W-1:0]   per_mille
);

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               pm_over;
    logic [MUL_P_W-1:0] prod_reg, prod_next;
    logic               pm_over_reg, pm_over_next;
    logic               done_reg, done_next;

    // one multiplier serves both quotients; a total at or past PM_LIMIT only saturates
    assign pm_over = used_ms >= USED_W'(PM_LIMIT);
    assign mul_a   = start_pm ? MUL_A_W'(used_ms[PM_X_W-1:0]) : MUL_A_W'(now_ms);
    assign mul_b   = start_pm ? MUL_B_W'(PM_RECIP) : MUL_B_W'(SEC_RECIP);

    always_comb begin
        prod_next    = prod_reg;
        pm_over_next = pm_over_reg;
        done_next    = start_sec | start_pm;
        if (start_sec || start_pm) begin
            prod_next    = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
            pm_over_next = start_pm && pm_over;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg    <= prod_next;
        pm_over_reg <= pm_over_next;
    end

    assign done      = done_reg;
    assign second    = prod_reg[SEC_SHIFT +: SEC_W];
    assign per_mille = pm_over_reg ? '1 : prod_reg[PM_SHIFT +: PM_W];

endmodule

// File: hdl/swatu_dp.sv
// Datapath: bucket RAM, valid bits, aging, record, sum sweep and shared divider
`include "sliding_window_airtime_tracker_unit_assert.svh"

module swatu_dp import swatu_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    output dp_sta_t             sta,
    input  logic                cfg_valid,
    input  logic [LIMIT_W-1:0]  cfg_airtime_limit_ms,
    input  logic [REQ_W-1:0]    s_req_type,
    input  logic [TIME_W-1:0]   s_now_ms,
    input  logic [AIR_W-1:0]    s_airtime_ms,
    output logic [USED_W-1:0]   m_used_ms,
    output logic                m_allowed,
    output logic [PM_W-1:0]     m_used_per_mille
);

    // control state
    logic [LIMIT_W-1:0]     limit_reg;
    logic                   started_reg, started_next;
    logic [SEC_W-1:0]       cur_sec_reg, cur_sec_next;
    logic [IDX_W-1:0]       cur_idx_reg, cur_idx_next;
    logic [NUM_BUCKETS-1:0] vld_reg, vld_next;
    logic [CNT_W-1:0]       sum_cnt_reg, sum_cnt_next;

    // item payload
    logic [REQ_W-1:0]  req_reg;
    logic [TIME_W-1:0] now_reg;
    logic [AIR_W-1:0]  air_reg;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [USED_W-1:0] used_reg;
    logic              rvld_reg;
    logic [USED_W-1:0] out_used_reg;
    logic              out_allowed_reg;
    logic [PM_W-1:0]   out_pm_reg;

    // divider
    logic              div_done;
    logic [SEC_W-1:0]  div_sec;
    logic [PM_W-1:0]   div_pm;

    // RAM
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [BKT_W-1:0] ram_rdata;
    logic [BKT_W-1:0] ram_wdata;
    logic [BKT_W-1:0] bkt_val;
    logic [BKT_W:0]   rec_sum;

    // aging
    logic [SEC_W-1:0]       age_sec;
    logic [SEC_W-1:0]       age_diff;
    logic                   age_full;
    logic [DIST_W-1:0]      age_steps;
    logic [DIST_W-1:0]      age_dist [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] age_mask;
    logic [DIST_W-1:0]      idx_adv;
    logic [DIST_W-1:0]      idx_wrap;

    logic [USED_W:0]   allow_sum;
    logic              allow_ok;

    // ---------------- divider: now / BUCKET_MS, then used * 1000 / WINDOW_MS
    swatu_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start_sec (cmd.div_start_now),
        .start_pm  (cmd.div_start_pm),
        .now_ms    (now_reg),
        .used_ms   (used_reg),
        .done      (div_done),
        .second    (div_sec),
        .per_mille (div_pm)
    );

    // ---------------- bucket RAM; an entry with a clear valid bit reads as zero
    assign ram_re    = cmd.rec_rd || (cmd.sum_step && (sum_cnt_reg < CNT_W'(NUM_BUCKETS)));
    assign ram_raddr = cmd.rec_rd ? cur_idx_reg : sum_cnt_reg[IDX_W-1:0];
    assign bkt_val   = rvld_reg ? ram_rdata : '0;
    assign rec_sum   = {1'b0, bkt_val} + (BKT_W + 1)'(air_reg);
    assign ram_wdata = rec_sum[BKT_W] ? '1 : rec_sum[BKT_W-1:0];

    swatu_ram #(
        .WIDTH (BKT_W),
        .DEPTH (NUM_BUCKETS)
    ) u_bkt_ram (
        .aclk  (aclk),
        .we    (cmd.rec_wr),
        .waddr (cur_idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------- aging
    // Bucket rows are relative: after any full clear the current row restarts at 0.
    assign age_sec   = div_sec;
    assign age_diff  = age_sec - cur_sec_reg;
    assign age_full  = (age_sec < cur_sec_reg) || (age_diff >= SEC_W'(NUM_BUCKETS));
    assign age_steps = DIST_W'(age_diff[IDX_W-1:0]);

    // distance of each row past the current one; rows within the step count expire
    always_comb begin
        for (int i = 0; i < NUM_BUCKETS; i++) begin
            if (IDX_W'(i) > cur_idx_reg) begin
                age_dist[i] = DIST_W'(i) - DIST_W'(cur_idx_reg) - DIST_W'(1);
            end else begin
                age_dist[i] = DIST_W'(i + NUM_BUCKETS) - DIST_W'(cur_idx_reg) - DIST_W'(1);
            end
            age_mask[i] = age_dist[i] < age_steps;
        end
    end

    assign idx_adv  = DIST_W'(cur_idx_reg) + age_steps;
    assign idx_wrap = (idx_adv >= DIST_W'(NUM_BUCKETS)) ? idx_adv - DIST_W'(NUM_BUCKETS)
                                                        : idx_adv;

    always_comb begin
        started_next = started_reg;
        cur_sec_next = cur_sec_reg;
        cur_idx_next = cur_idx_reg;
        vld_next     = vld_reg;
        if (cmd.clear_all) begin
            started_next = 1'b0;
            cur_sec_next = '0;
            cur_idx_next = '0;
            vld_next     = '0;
        end else if (cmd.age) begin
            if (!started_reg) begin
                started_next = 1'b1;
                cur_sec_next = age_sec;
                cur_idx_next = '0;
            end else if (age_sec != cur_sec_reg) begin
                cur_sec_next = age_sec;
                if (age_full) begin
                    vld_next     = '0;
                    cur_idx_next = '0;
                end else begin
                    vld_next     = vld_reg & ~age_mask;
                    cur_idx_next = idx_wrap[IDX_W-1:0];
                end
            end
        end else if (cmd.rec_wr) begin
            vld_next[cur_idx_reg] = 1'b1;
        end
    end

    // ---------------- sum sweep: read row n, add row n-1 (read data is registered)
    always_comb begin
        sum_cnt_next = sum_cnt_reg;
        acc_next     = acc_reg;
        if (cmd.sum_clr) begin
            sum_cnt_next = '0;
            acc_next     = '0;
        end else if (cmd.sum_step) begin
            if (sum_cnt_reg != CNT_W'(NUM_BUCKETS)) begin
                sum_cnt_next = sum_cnt_reg + CNT_W'(1);
            end
            if (sum_cnt_reg != '0) begin
                acc_next = acc_reg + ACC_W'(bkt_val);
            end
        end
    end

    // ---------------- result
    assign allow_sum = (USED_W + 1)'(used_reg) + (USED_W + 1)'(air_reg);
    assign allow_ok  = allow_sum <= (USED_W + 1)'(limit_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= LIMIT_RESET;
            started_reg <= 1'b0;
            cur_sec_reg <= '0;
            cur_idx_reg <= '0;
            vld_reg     <= '0;
            sum_cnt_reg <= '0;
        end else begin
            if (cfg_valid) begin
                limit_reg <= cfg_airtime_limit_ms;
            end
            started_reg <= started_next;
            cur_sec_reg <= cur_sec_next;
            cur_idx_reg <= cur_idx_next;
            vld_reg     <= vld_next;
            sum_cnt_reg <= sum_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            req_reg <= s_req_type;
            now_reg <= s_now_ms;
            air_reg <= s_airtime_ms;
        end
        if (ram_re) begin
            rvld_reg <= vld_reg[ram_raddr];
        end
        acc_reg <= acc_next;
        if (cmd.used_latch) begin
            used_reg <= (acc_reg > ACC_W'(USED_MAX)) ? USED_MAX : acc_reg[USED_W-1:0];
        end
        if (cmd.out_load) begin
            out_used_reg    <= used_reg;
            out_allowed_reg <= allow_ok;
            out_pm_reg      <= div_pm;
        end
    end

    assign sta.req      = req_reg;
    assign sta.div_done = div_done;
    assign sta.sum_last = (sum_cnt_reg == CNT_W'(NUM_BUCKETS));

    assign m_used_ms        = out_used_reg;
    assign m_allowed        = out_allowed_reg;
    assign m_used_per_mille = out_pm_reg;

    `SWATU_ASSERT(a_clear_empties, cmd.clear_all |=> (vld_reg == '0 && !started_reg), "clear left live buckets")
    `SWATU_ASSERT(a_div_one_start, !(cmd.div_start_now && cmd.div_start_pm), "two divisions started at once")
    `SWATU_ASSERT(a_idx_range, cur_idx_reg < IDX_W'(NUM_BUCKETS), "current bucket row out of range")

endmodule

// File: hdl/swatu_ctrl.sv
// Controller: sequences one item through divide or clear, age, record, sum and result
`include "sliding_window_airtime_tracker_unit_assert.svh"

module swatu_ctrl import swatu_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  dp_sta_t sta,
    output dp_cmd_t cmd
);

    typedef enum logic [11:0] {
        ST_IDLE      = 12'b0000_0000_0001,
        ST_DIVN_GO   = 12'b0000_0000_0010,
        ST_DIVN_WAIT = 12'b0000_0000_0100,
        ST_CLR       = 12'b0000_0000_1000,
        ST_AGE       = 12'b0000_0001_0000,
        ST_REC_RD    = 12'b0000_0010_0000,
        ST_REC_WR    = 12'b0000_0100_0000,
        ST_SUM       = 12'b0000_1000_0000,
        ST_USED      = 12'b0001_0000_0000,
        ST_DIVP_GO   = 12'b0010_0000_0000,
        ST_DIVP_WAIT = 12'b0100_0000_0000,
        ST_FIN       = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DIVN_GO;
                end
            end
            ST_DIVN_GO: begin
                if (sta.req == REQ_CLEAR) begin
                    state_next = ST_CLR;
                end else begin
                    cmd.div_start_now = 1'b1;
                    state_next        = ST_DIVN_WAIT;
                end
            end
            ST_DIVN_WAIT: begin
                if (sta.div_done) begin
                    state_next = ST_AGE;
                end
            end
            ST_CLR: begin
                cmd.clear_all = 1'b1;
                cmd.sum_clr   = 1'b1;
                state_next    = ST_SUM;
            end
            ST_AGE: begin
                cmd.age     = 1'b1;
                cmd.sum_clr = 1'b1;
                state_next  = (sta.req == REQ_RECORD) ? ST_REC_RD : ST_SUM;
            end
            ST_REC_RD: begin
                cmd.rec_rd = 1'b1;
                state_next = ST_REC_WR;
            end
            ST_REC_WR: begin
                cmd.rec_wr  = 1'b1;
                cmd.sum_clr = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_step = 1'b1;
                if (sta.sum_last) begin
                    state_next = ST_USED;
                end
            end
            ST_USED: begin
                cmd.used_latch = 1'b1;
                state_next     = ST_DIVP_GO;
            end
            ST_DIVP_GO: begin
                cmd.div_start_pm = 1'b1;
                state_next       = ST_DIVP_WAIT;
            end
            ST_DIVP_WAIT: begin
                if (sta.div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // result waits here only while the previous one is still unread
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    `SWATU_ASSERT(a_one_item, (s_valid && s_ready) |=> !s_ready, "second item taken while busy")
    `SWATU_ASSERT(a_no_overwrite, cmd.out_load |-> (!m_valid_reg || m_ready), "unread result overwritten")
    `SWATU_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (state_reg == ST_IDLE && !m_valid_reg), "reset did not idle")

endmodule
